// ===== rtl/core/bva_pkg.sv =====
// Package for the binned variogram accumulator: field widths, request codes,
// register indexes, reset values and the structs passed between the core modules.
// No dependencies.
package bva_pkg;

	// Default number of bin edges the bin store is sized for
	localparam int MAX_EDGES_DEF = 64;

	// Field widths
	localparam int MODE_W     = 2;
	localparam int DIST_W     = 32;
	localparam int VAL_W      = 24;
	localparam int BINID_W    = 6;
	localparam int MOM_W      = 64;
	localparam int CNT_W      = 32;
	localparam int EDGE_OUT_W = 40;
	localparam int NEDGE_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACC   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIN_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_EDGES = 2'd2;

	// Register reset values
	localparam logic [DIST_W-1:0]  BIN_START_RST = 32'd0;
	localparam logic [DIST_W-1:0]  BIN_STEP_RST  = 32'd65536;
	localparam logic [NEDGE_W-1:0] NUM_EDGES_RST = 7'd64;

	// Edge search control
	typedef struct packed {
		logic start;
		logic is_read;
	} srch_ctl_t;

	// Bin store control
	typedef struct packed {
		logic clear;
		logic rd_en;
		logic wr_en;
		logic acc;
	} store_ctl_t;

	// One result
	typedef struct packed {
		logic                  found;
		logic [BINID_W-1:0]    index;
		logic [MOM_W-1:0]      moment;
		logic [CNT_W-1:0]      count;
		logic [EDGE_OUT_W-1:0] lower_edge;
	} result_t;

endpackage

// ===== rtl/core/bva_if.sv =====
// Channel interfaces of the binned variogram accumulator: pair request,
// result and register write. Depends on bva_pkg.

interface bva_req_if;
	logic                              valid;
	logic                              ready;
	logic [bva_pkg::MODE_W-1:0]        mode;
	logic [bva_pkg::DIST_W-1:0]        distance;
	logic signed [bva_pkg::VAL_W-1:0]  value_a;
	logic signed [bva_pkg::VAL_W-1:0]  value_b;
	logic                              a_valid;
	logic                              b_valid;
	logic [bva_pkg::BINID_W-1:0]       read_bin;

	modport source (output valid, mode, distance, value_a, value_b, a_valid, b_valid,
		read_bin, input ready);
	modport sink (input valid, mode, distance, value_a, value_b, a_valid, b_valid,
		read_bin, output ready);
endinterface

interface bva_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              bin_found;
	logic [bva_pkg::BINID_W-1:0]       bin_index;
	logic [bva_pkg::MOM_W-1:0]         moment_sum;
	logic [bva_pkg::CNT_W-1:0]         pair_count;
	logic [bva_pkg::EDGE_OUT_W-1:0]    bin_lower_edge;

	modport source (output valid, bin_found, bin_index, moment_sum, pair_count,
		bin_lower_edge, input ready);
	modport sink (input valid, bin_found, bin_index, moment_sum, pair_count,
		bin_lower_edge, output ready);
endinterface

interface bva_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bva_pkg::CFG_IDX_W-1:0]     index;
	logic [bva_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bva_search.sv =====
// Edge search: finds the bin of a distance, or takes the bits of a read bin, one index
// bit per cycle, MSB first, building the lower edge by shifted adds of the step. Depends on bva_pkg.
module bva_search #(
	parameter int MAX_EDGES = bva_pkg::MAX_EDGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bva_pkg::srch_ctl_t            ctl,
	input  logic [bva_pkg::DIST_W-1:0]    bin_start,
	input  logic [bva_pkg::DIST_W-1:0]    bin_step,
	input  logic [bva_pkg::DIST_W-1:0]    distance,
	input  logic [bva_pkg::BINID_W-1:0]   read_bin,
	input  logic [$clog2(MAX_EDGES)-1:0]  nbins,
	output logic                          last,
	output logic [$clog2(MAX_EDGES)-1:0]  bin_idx,
	output logic [bva_pkg::DIST_W+$clog2(MAX_EDGES)-1:0] lower_edge
);

	localparam int BW = $clog2(MAX_EDGES);
	localparam int EW = bva_pkg::DIST_W + BW;
	localparam int KW = (BW > 1) ? $clog2(BW) : 1;

	logic          busy_q;
	logic          is_read_q;
	logic [KW-1:0] k_q;
	logic [BW-1:0] h_q;
	logic [EW-1:0] e_q;

	logic [BW-1:0] cand;
	logic [EW-1:0] cand_e;
	logic [BW-1:0] rsel;
	logic          take;

	// Trial: set bit k of the index and move the edge by step << k
	always_comb begin
		cand   = h_q | (BW'(1) << k_q);
		cand_e = e_q + (EW'(bin_step) << k_q);
		rsel   = BW'(read_bin);
		if (is_read_q) begin
			take = rsel[k_q];
		end else begin
			take = (cand < nbins) && (cand_e <= EW'(distance));
		end
	end

	// Bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			is_read_q <= 1'b0;
			k_q       <= '0;
		end else if (ctl.start) begin
			busy_q    <= 1'b1;
			is_read_q <= ctl.is_read;
			k_q       <= KW'(BW - 1);
		end else if (busy_q) begin
			if (k_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q - KW'(1);
			end
		end
	end

	// Index and edge so far
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			h_q <= '0;
			e_q <= EW'(bin_start);
		end else if (busy_q && take) begin
			h_q <= cand;
			e_q <= cand_e;
		end
	end

	assign last       = busy_q && (k_q == '0);
	assign bin_idx    = h_q;
	assign lower_edge = e_q;

endmodule

// ===== rtl/core/bva_bin_store.sv =====
// Bin store: one memory of {moment, count} words with per-bin valid bits, the
// squared difference and the saturating read-modify-write. Depends on bva_pkg.
module bva_bin_store #(
	parameter int MAX_EDGES = bva_pkg::MAX_EDGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bva_pkg::store_ctl_t                 ctl,
	input  logic [$clog2(MAX_EDGES)-1:0]        addr,
	input  logic signed [bva_pkg::VAL_W-1:0]    value_a,
	input  logic signed [bva_pkg::VAL_W-1:0]    value_b,
	output logic [bva_pkg::MOM_W-1:0]           moment,
	output logic [bva_pkg::CNT_W-1:0]           count
);

	localparam int DEPTH = MAX_EDGES - 1;
	localparam int MW    = bva_pkg::MOM_W;
	localparam int CW    = bva_pkg::CNT_W;
	localparam int DW    = bva_pkg::VAL_W + 1;
	localparam int WW    = MW + CW;

	logic [WW-1:0]     mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [WW-1:0]     rd_q;
	logic              vld_rd_q;

	logic signed [DW-1:0] diff;
	logic [DW-1:0]        mag;
	logic [DW-1:0]        mag_q;
	logic [2*DW-1:0]      sq_q;

	logic [MW-1:0] cur_m;
	logic [CW-1:0] cur_c;
	logic [MW:0]   sum;
	logic [MW-1:0] new_m;
	logic [CW-1:0] new_c;

	// |a - b| and its square, one register each; operands hold for the whole request
	always_comb begin
		diff = DW'(value_a) - DW'(value_b);
		mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
	end

	always_ff @(posedge clk) begin
		mag_q <= mag;
		sq_q  <= mag_q * mag_q;
	end

	// Saturating update of the bin read last cycle; an unwritten bin reads as zero
	always_comb begin
		cur_m = vld_rd_q ? rd_q[WW-1:CW] : '0;
		cur_c = vld_rd_q ? rd_q[CW-1:0] : '0;
		sum   = {1'b0, cur_m} + (MW + 1)'(sq_q);
		new_m = sum[MW] ? '1 : sum[MW-1:0];
		new_c = (&cur_c) ? cur_c : cur_c + CW'(1);
		moment = ctl.acc ? new_m : cur_m;
		count  = ctl.acc ? new_c : cur_c;
	end

	// Valid bits: cleared at once by reset or a clear request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.clear) begin
			vld_q <= '0;
		end else if (ctl.wr_en) begin
			vld_q[addr] <= 1'b1;
		end
	end

	// Memory with registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= {new_m, new_c};
		end
		if (ctl.rd_en) begin
			rd_q     <= mem[addr];
			vld_rd_q <= vld_q[addr];
		end
	end

endmodule

// ===== rtl/core/binned_variogram_accumulator_unit.sv =====
// Top level of the binned variogram accumulator: register file, request
// sequencer and result register. Depends on bva_pkg, bva_if, bva_search, bva_bin_store.
// Accumulate and read requests go through a bit-serial search of the bin index, MSB
// first, then a memory read and an update; clear and unused-mode requests go from
// idle straight to the update state. The result sits in an output
// register; a new request is taken while it waits. Reset (arst_n low) restores
// register defaults and marks every bin empty at once; no clearing pass is needed.
module binned_variogram_accumulator_unit #(
	parameter int MAX_EDGES = bva_pkg::MAX_EDGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bva_req_if.sink     req,
	bva_rsp_if.source   rsp,
	bva_cfg_if.sink     cfg
);

	localparam int BW = $clog2(MAX_EDGES);
	localparam int EW = bva_pkg::DIST_W + BW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_READ,
		S_UPDATE,
		S_HOLD
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [bva_pkg::DIST_W-1:0]  start_q;
	logic [bva_pkg::DIST_W-1:0]  step_q;
	logic [bva_pkg::NEDGE_W-1:0] nedge_q;

	// Request registers
	logic [bva_pkg::MODE_W-1:0]       mode_q;
	logic [bva_pkg::DIST_W-1:0]       dist_q;
	logic signed [bva_pkg::VAL_W-1:0] va_q;
	logic signed [bva_pkg::VAL_W-1:0] vb_q;
	logic                             ok_q;
	logic [bva_pkg::BINID_W-1:0]      rbin_q;
	logic                             hit_q;

	bva_pkg::result_t out_q;
	bva_pkg::result_t pend_q;
	bva_pkg::result_t res_now;
	logic             out_valid_q;

	logic                        accept;
	logic                        out_free;
	logic                        load_out;
	logic [31:0]                 nedge_w;
	logic                        has_bins;
	logic [BW-1:0]               nbins;
	logic                        hit_now;

	bva_pkg::srch_ctl_t  s_ctl;
	bva_pkg::store_ctl_t st_ctl;
	logic                s_last;
	logic [BW-1:0]       s_idx;
	logic [EW-1:0]       s_edge;
	logic [bva_pkg::MOM_W-1:0] st_moment;
	logic [bva_pkg::CNT_W-1:0] st_count;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= bva_pkg::BIN_START_RST;
			step_q  <= bva_pkg::BIN_STEP_RST;
			nedge_q <= bva_pkg::NUM_EDGES_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				bva_pkg::REG_BIN_START: start_q <= cfg.data;
				bva_pkg::REG_BIN_STEP:  step_q  <= cfg.data;
				bva_pkg::REG_NUM_EDGES: nedge_q <= bva_pkg::NEDGE_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// Bins in use: edges clamped to MAX_EDGES, fewer than two means none
	always_comb begin
		nedge_w  = (32'(nedge_q) > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : 32'(nedge_q);
		has_bins = (nedge_w >= 32'd2);
		nbins    = has_bins ? BW'(nedge_w - 32'd1) : '0;
	end

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	// Result register loads from the update or hold state once the output is free
	assign load_out  = ((state_q == S_UPDATE) || (state_q == S_HOLD)) && out_free;

	// Hit decision once the search has settled
	always_comb begin
		hit_now = 1'b0;
		case (mode_q)
			bva_pkg::MODE_ACC: begin
				hit_now = ok_q && has_bins
					&& (EW'(dist_q) >= EW'(start_q))
					&& (EW'(dist_q) < s_edge + EW'(step_q));
			end
			bva_pkg::MODE_READ: begin
				hit_now = has_bins && (32'(rbin_q) < 32'(nbins));
			end
			default: hit_now = 1'b0;
		endcase
	end

	// Control to the search and the bin store
	always_comb begin
		s_ctl.start   = accept && ((req.mode == bva_pkg::MODE_ACC)
			|| (req.mode == bva_pkg::MODE_READ));
		s_ctl.is_read = (req.mode == bva_pkg::MODE_READ);
		st_ctl.clear  = accept && (req.mode == bva_pkg::MODE_CLEAR);
		st_ctl.rd_en  = (state_q == S_READ) && hit_now;
		st_ctl.wr_en  = (state_q == S_UPDATE) && hit_q && (mode_q == bva_pkg::MODE_ACC);
		st_ctl.acc    = (mode_q == bva_pkg::MODE_ACC);
	end

	// Result of the current request; all zero on a miss, clear or unused mode
	always_comb begin
		if (hit_q) begin
			res_now.found      = 1'b1;
			res_now.index      = bva_pkg::BINID_W'(s_idx);
			res_now.moment     = st_moment;
			res_now.count      = st_count;
			res_now.lower_edge = bva_pkg::EDGE_OUT_W'(s_edge);
		end else begin
			res_now = '0;
		end
	end

	// Request payload, held for the whole request
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			dist_q <= req.distance;
			va_q   <= req.value_a;
			vb_q   <= req.value_b;
			ok_q   <= req.a_valid && req.b_valid;
			rbin_q <= req.read_bin;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			out_q       <= '0;
			pend_q      <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_ctl.start) begin
							state_q <= S_SEARCH;
						end else begin
							hit_q   <= 1'b0;
							state_q <= S_UPDATE;
						end
					end
				end
				S_SEARCH: begin
					if (s_last) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					hit_q   <= hit_now;
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (out_free) begin
						out_q   <= res_now;
						state_q <= S_IDLE;
					end else begin
						pend_q  <= res_now;
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						out_q   <= pend_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.bin_found      = out_q.found;
	assign rsp.bin_index      = out_q.index;
	assign rsp.moment_sum     = out_q.moment;
	assign rsp.pair_count     = out_q.count;
	assign rsp.bin_lower_edge = out_q.lower_edge;

	bva_search #(
		.MAX_EDGES (MAX_EDGES)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (s_ctl),
		.bin_start  (start_q),
		.bin_step   (step_q),
		.distance   (dist_q),
		.read_bin   (rbin_q),
		.nbins      (nbins),
		.last       (s_last),
		.bin_idx    (s_idx),
		.lower_edge (s_edge)
	);

	bva_bin_store #(
		.MAX_EDGES (MAX_EDGES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.addr    (s_idx),
		.value_a (va_q),
		.value_b (vb_q),
		.moment  (st_moment),
		.count   (st_count)
	);

endmodule

// ===== rtl/core/bva_checker.sv =====
// Port-level checks for the binned variogram accumulator, bound to the top level.
// Depends on bva_pkg and binned_variogram_accumulator_unit.
module bva_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic                               bin_found,
	input logic [bva_pkg::BINID_W-1:0]        bin_index,
	input logic [bva_pkg::MOM_W-1:0]          moment_sum,
	input logic [bva_pkg::CNT_W-1:0]          pair_count,
	input logic [bva_pkg::EDGE_OUT_W-1:0]     bin_lower_edge
);

	// A stalled result keeps its valid
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(bin_found) && $stable(bin_index)
			&& $stable(moment_sum) && $stable(pair_count) && $stable(bin_lower_edge))
		else $error("result payload changed while stalled");

	// One request at a time: ready drops right after a request is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Misses, clears and failed reads report all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !bin_found |-> (bin_index == '0) && (moment_sum == '0)
			&& (pair_count == '0) && (bin_lower_edge == '0))
		else $error("nonzero fields on a miss");

	// A bin with a nonzero moment has seen at least one pair
	a_moment_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bin_found && (moment_sum != '0) |-> (pair_count != '0))
		else $error("moment without pairs");

endmodule

bind binned_variogram_accumulator_unit bva_checker u_bva_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.bin_found      (rsp.bin_found),
	.bin_index      (rsp.bin_index),
	.moment_sum     (rsp.moment_sum),
	.pair_count     (rsp.pair_count),
	.bin_lower_edge (rsp.bin_lower_edge)
);

// ===== tb/binned_variogram_accumulator_unit_test.sv =====
// Self-checking bench for binned_variogram_accumulator_unit: directed and random pair
// requests under many bin settings, scored against a bin-tally tracker class.
// Depends on bva_pkg, bva_if and the unit itself.
module binned_variogram_accumulator_unit_test;

	localparam logic [bva_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int STORE_DEPTH    = bva_pkg::MAX_EDGES_DEF - 1;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int NUM_PHASES     = 12;
	localparam int SETTLE_CYCLES  = 24;

	// One pair request as the bench builds it
	typedef struct packed {
		logic [bva_pkg::MODE_W-1:0]  mode;
		logic [bva_pkg::DIST_W-1:0]  distance;
		logic [bva_pkg::VAL_W-1:0]   value_a;
		logic [bva_pkg::VAL_W-1:0]   value_b;
		logic                        a_valid;
		logic                        b_valid;
		logic [bva_pkg::BINID_W-1:0] read_bin;
	} pair_req_t;

	// Tracks register settings and bin contents, predicts each report and checks it
	class bin_tally_tracker;
		logic [bva_pkg::DIST_W-1:0]  bin_start;
		logic [bva_pkg::DIST_W-1:0]  bin_step;
		logic [bva_pkg::NEDGE_W-1:0] edge_total;
		logic [bva_pkg::MOM_W-1:0]   moment [STORE_DEPTH];
		logic [bva_pkg::CNT_W-1:0]   count [STORE_DEPTH];
		bva_pkg::result_t            expected_reports [$];
		int                          failures;
		int                          checked;
		int                          binned;
		int                          reads;

		function new();
			int i;
			bin_start  = bva_pkg::BIN_START_RST;
			bin_step   = bva_pkg::BIN_STEP_RST;
			edge_total = bva_pkg::NUM_EDGES_RST;
			for (i = 0; i < STORE_DEPTH; i++) begin
				moment[i] = '0;
				count[i]  = '0;
			end
			failures = 0;
			checked  = 0;
			binned   = 0;
			reads    = 0;
		endfunction

		function void apply_register(logic [bva_pkg::CFG_IDX_W-1:0] idx,
				logic [bva_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bva_pkg::REG_BIN_START: bin_start = data;
				bva_pkg::REG_BIN_STEP:  bin_step = data;
				bva_pkg::REG_NUM_EDGES: edge_total = data[bva_pkg::NEDGE_W-1:0];
				default: ;
			endcase
		endfunction

		// Edge counts above the store size are clipped; may go negative
		function int bins_in_use();
			if (edge_total > bva_pkg::NEDGE_W'(bva_pkg::MAX_EDGES_DEF))
				return bva_pkg::MAX_EDGES_DEF - 1;
			return int'(edge_total) - 1;
		endfunction

		// Edges are exact, wider than a distance
		function logic [63:0] edge_at(int h);
			return {32'd0, bin_start} + 64'(h) * {32'd0, bin_step};
		endfunction

		function bva_pkg::result_t report_for(int h);
			bva_pkg::result_t r;
			r.found      = 1'b1;
			r.index      = bva_pkg::BINID_W'(h);
			r.moment     = moment[h];
			r.count      = count[h];
			r.lower_edge = bva_pkg::EDGE_OUT_W'(edge_at(h));
			return r;
		endfunction

		function void note_request(pair_req_t p);
			bva_pkg::result_t r;
			int               nbins;
			int               lo;
			int               hi;
			int               mid;
			int               hit;
			int               diff;
			int               i;
			logic [63:0]      pair_dist;
			logic [63:0]      e0;
			logic [63:0]      mag;
			logic [63:0]      inc;
			logic [64:0]      total;
			r     = '0;
			nbins = bins_in_use();
			hit   = -1;
			case (p.mode)
				bva_pkg::MODE_CLEAR: begin
					for (i = 0; i < STORE_DEPTH; i++) begin
						moment[i] = '0;
						count[i]  = '0;
					end
				end
				bva_pkg::MODE_ACC: begin
					// binary search over the edges in use
					pair_dist = {32'd0, p.distance};
					lo        = 0;
					hi        = nbins - 1;
					while (lo <= hi && hit < 0) begin
						mid = (lo + hi) / 2;
						e0  = edge_at(mid);
						if (pair_dist >= e0 && pair_dist < edge_at(mid + 1))
							hit = mid;
						else if (pair_dist < e0)
							hi = mid - 1;
						else
							lo = mid + 1;
					end
					if (hit >= 0 && hit < STORE_DEPTH && p.a_valid && p.b_valid) begin
						// half the square at 25 fraction bits is diff squared
						diff  = $signed(p.value_a) - $signed(p.value_b);
						mag   = 64'((diff < 0) ? -diff : diff);
						inc   = mag * mag;
						total = {1'b0, moment[hit]} + {1'b0, inc};
						moment[hit] = total[64] ? '1 : total[63:0];
						if (count[hit] != '1)
							count[hit] = count[hit] + 1'b1;
						r = report_for(hit);
						binned++;
					end
				end
				bva_pkg::MODE_READ: begin
					if (int'(p.read_bin) < nbins && int'(p.read_bin) < STORE_DEPTH) begin
						r = report_for(int'(p.read_bin));
						reads++;
					end
				end
				default: ;
			endcase
			expected_reports.push_back(r);
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void check_result(bva_pkg::result_t got);
			bva_pkg::result_t want;
			if (expected_reports.size() == 0) begin
				$error("result with no pending request: bin_index %0d", got.index);
				failures++;
				return;
			end
			want = expected_reports.pop_front();
			checked++;
			if (got.found !== want.found) begin
				$error("bin_found: expected %0d, got %0d", want.found, got.found);
				failures++;
			end
			if (got.index !== want.index) begin
				$error("bin_index: expected %0d, got %0d", want.index, got.index);
				failures++;
			end
			if (got.moment !== want.moment) begin
				$error("moment_sum: expected %h, got %h", want.moment, got.moment);
				failures++;
			end
			if (got.count !== want.count) begin
				$error("pair_count: expected %0d, got %0d", want.count, got.count);
				failures++;
			end
			if (got.lower_edge !== want.lower_edge) begin
				$error("bin_lower_edge: expected %h, got %h", want.lower_edge,
					got.lower_edge);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	bit   hold_results;
	int   stall_cycles;
	int   n_requests;
	int   n_settings;
	bin_tally_tracker tracker;

	bva_req_if req_ch();
	bva_rsp_if rsp_ch();
	bva_cfg_if cfg_ch();

	binned_variogram_accumulator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic pair_req_t mk_req(logic [bva_pkg::MODE_W-1:0] mode,
			logic [bva_pkg::DIST_W-1:0] distance,
			logic [bva_pkg::VAL_W-1:0] a, logic [bva_pkg::VAL_W-1:0] b, logic av, logic bv,
			logic [bva_pkg::BINID_W-1:0] rb);
		pair_req_t p;
		p.mode     = mode;
		p.distance = distance;
		p.value_a  = a;
		p.value_b  = b;
		p.a_valid  = av;
		p.b_valid  = bv;
		p.read_bin = rb;
		return p;
	endfunction

	function automatic logic [bva_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return '0;
			3: return bva_pkg::VAL_W'($urandom_range(0, 255));
			default: return bva_pkg::VAL_W'($urandom);
		endcase
	endfunction

	// Mostly pairs aimed into a live bin, some at the range boundaries, some noise
	function automatic pair_req_t random_pair_req();
		pair_req_t   p;
		int          pick;
		int          nbins;
		int          h;
		logic [63:0] e;
		logic [63:0] span;
		logic [63:0] room;
		pick = $urandom_range(0, 99);
		if (pick < 76)
			p.mode = bva_pkg::MODE_ACC;
		else if (pick < 94)
			p.mode = bva_pkg::MODE_READ;
		else if (pick < 96)
			p.mode = bva_pkg::MODE_CLEAR;
		else
			p.mode = MODE_UNUSED;
		p.value_a  = pick_value();
		p.value_b  = pick_value();
		p.a_valid  = ($urandom_range(0, 99) >= 8);
		p.b_valid  = ($urandom_range(0, 99) >= 8);
		p.distance = $urandom;
		nbins = tracker.bins_in_use();
		pick  = $urandom_range(0, 99);
		if (pick < 72 && nbins > 0) begin
			h    = $urandom_range(0, nbins - 1);
			e    = tracker.edge_at(h);
			span = tracker.edge_at(h + 1) - e;
			room = 64'h1_0000_0000 - e;
			if (e < 64'h1_0000_0000 && span != 0) begin
				if (span > room)
					span = room;
				p.distance = bva_pkg::DIST_W'(e + {$urandom, $urandom} % span);
			end
		end else if (pick < 84 && nbins > 0) begin
			// on or just below the first or the last edge
			e = tracker.edge_at($urandom_range(0, 1) ? nbins : 0) - 64'($urandom_range(0, 1));
			p.distance = bva_pkg::DIST_W'(e);
		end
		if (nbins > 0 && $urandom_range(0, 99) < 85)
			p.read_bin = bva_pkg::BINID_W'($urandom_range(0, nbins - 1));
		else
			p.read_bin = bva_pkg::BINID_W'($urandom_range(0, 63));
		return p;
	endfunction

	// Offer one request, with random gaps, and note it once taken
	task automatic issue_request(pair_req_t p);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 11) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.mode     = p.mode;
		req_ch.distance = p.distance;
		req_ch.value_a  = p.value_a;
		req_ch.value_b  = p.value_b;
		req_ch.a_valid  = p.a_valid;
		req_ch.b_valid  = p.b_valid;
		req_ch.read_bin = p.read_bin;
		req_ch.valid    = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(p);
		n_requests++;
	endtask

	task automatic wait_all_reports();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	task automatic set_register(logic [bva_pkg::CFG_IDX_W-1:0] idx,
			logic [bva_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.apply_register(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			rsp_ch.ready = steady ? 1'b1 : ($urandom_range(0, 99) >= 11);
		end
	end

	// Score every accepted result
	always @(posedge clk) begin : result_monitor
		bva_pkg::result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.found      = rsp_ch.bin_found;
			got.index      = rsp_ch.bin_index;
			got.moment     = rsp_ch.moment_sum;
			got.count      = rsp_ch.pair_count;
			got.lower_edge = rsp_ch.bin_lower_edge;
			tracker.check_result(got);
		end
	end

	// Watchdog: too long with no handshake on any channel
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL binned_variogram_accumulator_unit");
			$finish;
		end
	end

	// Main sequence
	initial begin : stimulus
		int                           ph;
		int                           k;
		int                           i;
		int                           n_items;
		int                           rot;
		logic [bva_pkg::DIST_W-1:0]   s;
		logic [bva_pkg::DIST_W-1:0]   st;
		logic [bva_pkg::NEDGE_W-1:0]  ne;
		tracker         = new();
		n_requests      = 0;
		n_settings      = 1;
		steady          = 1'b0;
		hold_results    = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.mode     = bva_pkg::MODE_CLEAR;
		req_ch.distance = '0;
		req_ch.value_a  = '0;
		req_ch.value_b  = '0;
		req_ch.a_valid  = 1'b0;
		req_ch.b_valid  = 1'b0;
		req_ch.read_bin = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = bva_pkg::REG_BIN_START;
		cfg_ch.data     = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset settings: 63 unit bins from zero
		issue_request(mk_req(bva_pkg::MODE_READ, '0, '0, '0, 1'b0, 1'b0, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, '0, 24'h7FFFFF, 24'h800000,
			1'b1, 1'b1, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h0000FFFF, 24'h800000, 24'h7FFFFF,
			1'b1, 1'b1, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h003EFFFF, 24'h123456, 24'hEDCBA9,
			1'b1, 1'b1, 6'd0));
		// last edge and beyond miss
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h003F0000, 24'h000100, 24'h000001,
			1'b1, 1'b1, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'hFFFFFFFF, 24'hFFFFFF, 24'h000000,
			1'b1, 1'b1, 6'h3F));
		// invalid values are skipped
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h00010000, 24'h000001, 24'h000002,
			1'b0, 1'b1, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h00010000, 24'h000001, 24'h000002,
			1'b1, 1'b0, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h00010000, 24'h000001, 24'h000002,
			1'b0, 1'b0, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h00010000, 24'h400000, 24'h400000,
			1'b1, 1'b1, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h00020000, 24'hFFFFFF, 24'h000001,
			1'b1, 1'b1, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_READ, '0, '0, '0, 1'b0, 1'b0, 6'd62));
		issue_request(mk_req(bva_pkg::MODE_READ, '1, '1, '1, 1'b1, 1'b1, 6'd63));
		issue_request(mk_req(bva_pkg::MODE_READ, '0, '0, '0, 1'b0, 1'b0, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_READ, '0, '0, '0, 1'b0, 1'b0, 6'd1));
		issue_request(mk_req(MODE_UNUSED, 32'h00010000, 24'h000005, 24'h000009, 1'b1, 1'b1,
			6'd63));
		issue_request(mk_req(bva_pkg::MODE_CLEAR, '1, '1, '1, 1'b1, 1'b1, 6'd63));
		issue_request(mk_req(bva_pkg::MODE_READ, '0, '0, '0, 1'b0, 1'b0, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_READ, '0, '0, '0, 1'b0, 1'b0, 6'd62));
		issue_request(mk_req(bva_pkg::MODE_ACC, 32'h00208000, 24'h2AAAAA, 24'hD55555,
			1'b1, 1'b1, 6'd0));
		issue_request(mk_req(bva_pkg::MODE_READ, '0, '0, '0, 1'b0, 1'b0, 6'd32));
		wait_all_reports();

		// Random phases, each under its own bin settings
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					s = '0; st = 32'd1; ne = 7'd64; n_items = 200;
				end
				1: begin
					s = '1; st = '1; ne = 7'd64; n_items = 60;
				end
				2: begin
					s = bva_pkg::DIST_W'($urandom_range(0, 65535)); st = '0;
					ne = bva_pkg::NEDGE_W'($urandom_range(2, 64)); n_items = 40;
				end
				3: begin
					s = '0; st = bva_pkg::BIN_STEP_RST; ne = 7'd0; n_items = 40;
				end
				4: begin
					s = '0; st = bva_pkg::BIN_STEP_RST; ne = 7'd1; n_items = 40;
				end
				5: begin
					s = bva_pkg::DIST_W'($urandom_range(0, 1 << 16));
					st = bva_pkg::DIST_W'($urandom_range(1, 1 << 20)); ne = 7'h7F;
					n_items = 200;
				end
				6: begin
					s = $urandom; st = $urandom; ne = 7'd2; n_items = 150;
				end
				default: begin
					s = bva_pkg::DIST_W'($urandom_range(0, 1 << 24));
					st = bva_pkg::DIST_W'($urandom_range(1, 1 << 24));
					ne = bva_pkg::NEDGE_W'($urandom_range(2, 64)); n_items = 200;
				end
			endcase
			wait_all_reports();
			rot = $urandom_range(0, 2);
			for (k = 0; k < 3; k++) begin
				case ((rot + k) % 3)
					0: set_register(bva_pkg::REG_BIN_START, s);
					1: set_register(bva_pkg::REG_BIN_STEP, st);
					default: set_register(bva_pkg::REG_NUM_EDGES, bva_pkg::CFG_DATA_W'(ne));
				endcase
			end
			n_settings++;
			steady = (ph == 8);
			// long result stall while requests keep coming
			if (ph == 5)
				hold_results = 1'b1;
			for (i = 0; i < n_items; i++)
				issue_request(random_pair_req());
		end
		steady = 1'b0;

		wait_all_reports();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d expected results never arrived", tracker.pending());
			tracker.failures++;
		end
		$display("Ran %0d requests, %0d bin settings: %0d checked, %0d binned, %0d read.",
			n_requests, n_settings, tracker.checked, tracker.binned, tracker.reads);
		$display("Zero and full-scale bin widths, 0/1/2/127 edges, %0d-cycle result stall.",
			HOLD_CYCLES);
		if (tracker.failures == 0)
			$display("PASS binned_variogram_accumulator_unit");
		else
			$display("FAIL binned_variogram_accumulator_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/bva_pkg.sv
rtl/core/bva_if.sv
rtl/core/bva_search.sv
rtl/core/bva_bin_store.sv
rtl/core/binned_variogram_accumulator_unit.sv
rtl/core/bva_checker.sv
tb/binned_variogram_accumulator_unit_test.sv
